FILE: rtl/pdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared types and constants for the packed integer sampled dot product.
// ----------------------------------------------------------------------------
package pdp_pkg;

   localparam int WORD_BITS   = 32;
   localparam int ALIGN       = 8;
   localparam int SLOT_W      = 20;
   localparam int LANE_W      = 3;
   localparam int ADDR_W      = 23;
   localparam int PREC_W      = 2;
   localparam int VLEN_W      = 4;
   localparam int ADDR_CALC_W = 32;
   localparam int PROD_W      = SLOT_W + VLEN_W;

   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_PRECISION  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LEN = 1'd1;

   localparam logic [PREC_W-1:0] PREC_4BIT  = 2'd0;
   localparam logic [PREC_W-1:0] PREC_8BIT  = 2'd1;
   localparam logic [PREC_W-1:0] PREC_16BIT = 2'd2;

   localparam logic [PREC_W-1:0] PREC_RESET = PREC_8BIT;
   localparam logic [VLEN_W-1:0] VLEN_RESET = 4'd1;

   typedef struct packed {
      logic [WORD_BITS-1:0] lhs_word;
      logic [WORD_BITS-1:0] rhs_word;
      logic                 last_word;
      logic [SLOT_W-1:0]    slot_index;
      logic [LANE_W-1:0]    vector_lane;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] dot_value;
      logic [ADDR_W-1:0]           out_address;
   } rsp_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] partial;
      logic                 last;
      logic [ADDR_W-1:0]    addr;
   } work_type;

endpackage

FILE: rtl/pdp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdp_front
// Accepts items, holds configuration, forms the word dot product and the
// output address, and hands one work entry per item to the queue.
// ----------------------------------------------------------------------------
module pdp_front
   import pdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  push_valid,
   input  logic                  push_full,
   output work_type              push_data
);

   logic [PREC_W-1:0] prec_ff, prec_in;
   logic [VLEN_W-1:0] vlen_ff, vlen_in;
   logic              stage_valid_ff, stage_valid_in;
   work_type          stage_data_ff, stage_data_in;

   logic                  stage_open;
   logic [11:0]           sum4;
   logic [17:0]           sum8;
   logic [WORD_BITS:0]    sum16;
   logic [WORD_BITS-1:0]  word_dot;
   logic [SLOT_W-1:0]     slot_hi;
   logic [SLOT_W-1:0]     slot_lo;
   logic [PROD_W-1:0]     slot_prod;
   logic [ADDR_CALC_W-1:0] addr_full;

   always_comb begin
      prec_in = prec_ff;
      vlen_in = vlen_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_PRECISION:  prec_in = csr_wdata[PREC_W-1:0];
            CSR_VECTOR_LEN: vlen_in = csr_wdata[VLEN_W-1:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      sum4  = '0;
      sum8  = '0;
      sum16 = '0;
      for (int i = 0; i < WORD_BITS / 4; i++) begin
         sum4 = sum4 + 12'(req_data.lhs_word[4*i +: 4] * req_data.rhs_word[4*i +: 4]);
      end
      for (int i = 0; i < WORD_BITS / 8; i++) begin
         sum8 = sum8 + 18'(req_data.lhs_word[8*i +: 8] * req_data.rhs_word[8*i +: 8]);
      end
      for (int i = 0; i < WORD_BITS / 16; i++) begin
         sum16 = sum16 + (WORD_BITS+1)'(req_data.lhs_word[16*i +: 16]
                                      * req_data.rhs_word[16*i +: 16]);
      end
      case (prec_ff)
         PREC_4BIT: word_dot = WORD_BITS'(sum4);
         PREC_8BIT: word_dot = WORD_BITS'(sum8);
         default:   word_dot = sum16[WORD_BITS-1:0];
      endcase
   end

   always_comb begin
      slot_hi   = SLOT_W'(req_data.slot_index / ALIGN);
      slot_lo   = SLOT_W'(req_data.slot_index % ALIGN);
      slot_prod = PROD_W'(slot_hi) * PROD_W'(vlen_ff);
      addr_full = ADDR_CALC_W'(slot_prod) * ADDR_CALC_W'(ALIGN)
                + ADDR_CALC_W'(req_data.vector_lane) * ADDR_CALC_W'(ALIGN)
                + ADDR_CALC_W'(slot_lo);
   end

   assign stage_open = !stage_valid_ff || !push_full;
   assign req_stall  = !stage_open;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_data_in  = stage_data_ff;
      if (stage_open) begin
         stage_valid_in        = req_valid;
         stage_data_in.partial = word_dot;
         stage_data_in.last    = req_data.last_word;
         stage_data_in.addr    = addr_full[ADDR_W-1:0];
      end
   end

   assign push_valid = stage_valid_ff;
   assign push_data  = stage_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prec_ff        <= PREC_RESET;
         vlen_ff        <= VLEN_RESET;
         stage_valid_ff <= 1'b0;
      end else begin
         prec_ff        <= prec_in;
         vlen_ff        <= vlen_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_data_ff <= stage_data_in;
   end

endmodule

FILE: rtl/pdp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdp_queue
// Short register queue of work entries between the front and back parts.
// ----------------------------------------------------------------------------
module pdp_queue
   import pdp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_full,
   input  work_type push_data,
   output logic     pop_valid,
   input  logic     pop_take,
   output work_type pop_data
);

   work_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_valid && pop_take;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/pdp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdp_back
// Adds each work entry into the running sum and emits the result item on the
// last word of a dot product through an output register.
// ----------------------------------------------------------------------------
module pdp_back
   import pdp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     pop_valid,
   output logic     pop_take,
   input  work_type pop_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_data_ff, out_data_in;
   logic [WORD_BITS-1:0] total;
   logic                 do_pop;

   assign total    = acc_ff + pop_data.partial;
   assign pop_take = !pop_data.last || !out_valid_ff || !rsp_stall;
   assign do_pop   = pop_valid && pop_take;

   always_comb begin
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (do_pop) begin
         if (pop_data.last) begin
            acc_in                  = '0;
            out_valid_in            = 1'b1;
            out_data_in.dot_value   = total;
            out_data_in.out_address = pop_data.addr;
         end else begin
            acc_in = total;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

endmodule

FILE: rtl/packed_int_sampled_dot_product_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_int_sampled_dot_product_top
// Packed 4/8/16-bit unsigned dot product with sparse output addressing.
//
// Input channel req_*: one item per word pair, taken when req_valid is high
// and req_stall is low. Items accumulate into a 32-bit wrapping sum; an item
// with last_word set closes the dot product and yields one rsp_* item
// carrying the sum and its output address. Other items yield nothing.
// Throughput is one item per cycle while req_stall is low. A result passes
// through the front stage (multipliers and address), which loads it when
// its last item is taken, then a queue entry, then the output register.
// The csr_* port writes precision_mode (index 0) and vector_length (index 1);
// write only while the block is idle.
// Reset (synchronous) clears the running sum, empties the pipeline and sets
// precision_mode to 8-bit and vector_length to 1.
// When rsp_stall is held, the output register holds its item; once a last
// item heads the queue, the queue and front stage fill, and req_stall rises
// when both queue entries and the front stage hold items.
// ----------------------------------------------------------------------------
module packed_int_sampled_dot_product_top
   import pdp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic     push_valid;
   logic     push_full;
   work_type push_data;
   logic     pop_valid;
   logic     pop_take;
   work_type pop_data;

   pdp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push_valid   (push_valid),
      .push_full    (push_full),
      .push_data    (push_data)
   );

   pdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_data   (pop_data)
   );

   pdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_take  (pop_take),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
